### hdl/decimal_string_to_int_parser_unit_defines.svh
// Assertion macros for the decimal string parser checker.
// Included by the checker; depends on nothing else.
`ifndef DECIMAL_STRING_TO_INT_PARSER_UNIT_DEFINES_SVH
`define DECIMAL_STRING_TO_INT_PARSER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSIP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dsip checker: same-cycle rule violated");

// The consequent must hold in the cycle after the antecedent.
`define DSIP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dsip checker: next-cycle rule violated");

`endif

### hdl/dsip_pkg.sv
// Shared constants, types and widths of the decimal string parser.
// Used by every module of the block; depends on nothing.
`default_nettype none

package dsip_pkg;

    localparam int LENGTH_BITS = 8;
    localparam int CHAR_W      = 8;
    localparam int ACC_W       = 32;
    localparam int VALUE_W     = ACC_W + 1;
    localparam int PROD_W      = ACC_W + 4;
    localparam int IN_DATA_W   = CHAR_W;
    localparam int OUT_DATA_W  = ((VALUE_W + LENGTH_BITS + 7) / 8) * 8;
    localparam int OUT_USER_W  = 2;

    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    localparam logic [ACC_W-1:0]       U32_MAX = '1;
    localparam logic [ACC_W-1:0]       S32_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    typedef struct packed {
        logic                   active;
        logic [ACC_W-1:0]       acc;
        logic                   overflow;
        logic                   negative;
        logic                   sign_taken;
        logic [LENGTH_BITS-1:0] count;
    } parse_state_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] parsed_value;
        logic                      range_error;
        logic                      digits_found;
        logic [LENGTH_BITS-1:0]    consumed_length;
    } parse_result_t;

endpackage

`default_nettype wire

### hdl/decimal_string_to_int_parser_unit.sv
// Top level of the decimal string parser: stream ports, registers, config.
// Depends on dsip_pkg and dsip_step.
//
//   Channel   Dir  Handshake            Contents
//   s_        in   s_tvalid/s_tready    one string byte, first-of-number flag
//   m_        out  m_tvalid/m_tready    value, length, range error, digits flag
//   cfg_      in   cfg_wr_en            signed_mode
//
// One byte per cycle is sustained while m_ is not stalled; the result of a terminating
// byte goes through the input register, then the result register, before it shows on m_.
// The accumulate step (multiply by ten and add) runs once per item.
// Reset is synchronous, active low, and sets signed_mode to 1.
// A stalled result holds the pipeline; the input register still takes one item.
`default_nettype none

module decimal_string_to_int_parser_unit (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic                               cfg_wr_data,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // char_byte [7:0]
    input  wire logic [dsip_pkg::IN_DATA_W-1:0]     s_tdata,
    // first_byte
    input  wire logic                               s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // parsed_value [32:0], consumed_length [40:33], zero fill
    output logic [dsip_pkg::OUT_DATA_W-1:0]         m_tdata,
    // range_error [0], digits_found [1]
    output logic [dsip_pkg::OUT_USER_W-1:0]         m_tuser
);
    import dsip_pkg::*;

    logic                signed_mode_reg;
    logic                in_valid_reg;
    logic [CHAR_W-1:0]   in_char_reg;
    logic                in_first_reg;
    parse_state_t        state_reg;
    parse_state_t        state_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    parse_result_t       out_reg;
    parse_result_t       step_result;
    logic                step_emit;
    logic                out_free;
    logic                advance;

    dsip_step u_step (
        .signed_mode (signed_mode_reg),
        .char_byte   (in_char_reg),
        .first_byte  (in_first_reg),
        .state_cur   (state_reg),
        .state_next  (state_next),
        .emit        (step_emit),
        .result      (step_result)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance && step_emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            signed_mode_reg <= 1'b1;
            in_valid_reg    <= 1'b0;
            state_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                signed_mode_reg <= cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                state_reg <= state_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg  <= s_tdata[CHAR_W-1:0];
            in_first_reg <= s_tuser;
        end
        if (advance && step_emit) begin
            out_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'({out_reg.consumed_length, out_reg.parsed_value});
    assign m_tuser  = {out_reg.digits_found, out_reg.range_error};

endmodule

`default_nettype wire

### hdl/dsip_step.sv
// Combinational parse step: next parser state and the result for one byte.
// Depends on dsip_pkg.
`default_nettype none

module dsip_step (
    input  wire logic                          signed_mode,
    input  wire logic [dsip_pkg::CHAR_W-1:0]   char_byte,
    input  wire logic                          first_byte,
    input  wire dsip_pkg::parse_state_t        state_cur,
    output dsip_pkg::parse_state_t             state_next,
    output logic                               emit,
    output dsip_pkg::parse_result_t            result
);
    import dsip_pkg::*;

    parse_state_t           base;
    logic                   active;
    logic                   is_digit;
    logic                   is_sign;
    logic [PROD_W-1:0]      prod;
    logic [ACC_W-1:0]       mag;
    logic                   err;
    logic [LENGTH_BITS:0]   len_sum;

    always_comb begin
        // A first byte starts from a cleared number.
        base = first_byte ? '0 : state_cur;
        active = first_byte || state_cur.active;
        is_digit = (char_byte >= CHAR_ZERO) && (char_byte <= CHAR_NINE);
        is_sign = first_byte && signed_mode &&
                  ((char_byte == CHAR_PLUS) || (char_byte == CHAR_MINUS));

        // acc * 10 + digit as two shifts and two adds.
        prod = (PROD_W'(base.acc) << 3) + (PROD_W'(base.acc) << 1) +
               PROD_W'(char_byte[3:0]);

        state_next = state_cur;
        emit = 1'b0;
        if (active) begin
            state_next = base;
            state_next.active = 1'b1;
            if (is_sign) begin
                state_next.sign_taken = 1'b1;
                state_next.negative = (char_byte == CHAR_MINUS);
            end else if (is_digit) begin
                state_next.acc = prod[ACC_W-1:0];
                state_next.overflow = base.overflow || (|prod[PROD_W-1:ACC_W]);
                if (base.count != LEN_MAX) begin
                    state_next.count = base.count + 1'b1;
                end
            end else begin
                state_next.active = 1'b0;
                emit = 1'b1;
            end
        end

        mag = base.overflow ? U32_MAX : base.acc;
        err = base.overflow;
        if (signed_mode && mag[ACC_W-1]) begin
            mag = S32_MAX;
            err = 1'b1;
        end
        len_sum = {1'b0, base.count} + (LENGTH_BITS+1)'(base.sign_taken);

        if (base.count == '0) begin
            result = '0;
        end else begin
            result.parsed_value = (signed_mode && base.negative) ?
                                  -$signed({1'b0, mag}) : $signed({1'b0, mag});
            result.range_error = err;
            result.digits_found = 1'b1;
            result.consumed_length = len_sum[LENGTH_BITS] ? LEN_MAX :
                                     len_sum[LENGTH_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

### hdl/dsip_checker.sv
// Port-level checker for the decimal string parser, bound to the top level.
// Depends on dsip_pkg and decimal_string_to_int_parser_unit_defines.svh.
`default_nettype none

`include "decimal_string_to_int_parser_unit_defines.svh"

module dsip_checker (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic                               m_tvalid,
    input wire logic                               m_tready,
    input wire logic [dsip_pkg::OUT_DATA_W-1:0]    m_tdata,
    input wire logic [dsip_pkg::OUT_USER_W-1:0]    m_tuser
);
    import dsip_pkg::*;

    logic no_digits;
    logic stalled;
    logic empty_item;
    logic full_item;
    logic [LENGTH_BITS-1:0] length_field;

    assign no_digits    = !m_tuser[1];
    assign stalled      = m_tvalid && !m_tready;
    assign empty_item   = m_tvalid && no_digits;
    assign full_item    = m_tvalid && !no_digits;
    assign length_field = m_tdata[VALUE_W +: LENGTH_BITS];

    // A result held under back-pressure keeps its valid and its payload.
    `DSIP_ASSERT_NXT(a_hold_valid, aclk, aresetn, stalled, m_tvalid)
    `DSIP_ASSERT_NXT(a_hold_data, aclk, aresetn, stalled, $stable(m_tdata) && $stable(m_tuser))

    // A number without digits reports all zeros and no range error.
    `DSIP_ASSERT_IMP(a_empty_zero, aclk, aresetn, empty_item, (m_tdata == '0) && !m_tuser[0])

    // A number with digits always reports a nonzero consumed length.
    `DSIP_ASSERT_IMP(a_len_nonzero, aclk, aresetn, full_item, length_field != '0)

endmodule

bind decimal_string_to_int_parser_unit dsip_checker u_dsip_checker (.*);

`default_nettype wire
